/* rtl/core/assert_macros.svh */
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, muted while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/ssmd_pkg.sv */
package ssmd_pkg;

    localparam int REQ_W    = 2;
    localparam int IDX_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int SCORE_W  = 7;
    localparam int EN_W     = 4;
    localparam int SEG_W    = 8;
    localparam int BRIGHT_W = 8;
    localparam int TICK_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [SEG_W-1:0] SEG_DARK = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DASH = 8'hBF;

    localparam logic [BRIGHT_W-1:0] LEFT_BRIGHT_RST  = 8'd100;
    localparam logic [BRIGHT_W-1:0] RIGHT_BRIGHT_RST = 8'd100;
    localparam logic [TICK_W-1:0]   GAP_TICKS_RST    = 10'd500;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_CHAR  = 2'd1,
        REQ_LEFT  = 2'd2,
        REQ_RIGHT = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_BRIGHT  = 2'd0,
        CFG_RIGHT_BRIGHT = 2'd1,
        CFG_GAP_TICKS    = 2'd2
    } t_cfg_idx;

    localparam logic [SEG_W-1:0] NUM_CODES [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam logic [SEG_W-1:0] ALPHA_CODES [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h90, 8'h89, 8'hCF, 8'h61,
        8'hBF, 8'hC7, 8'hBF, 8'hAB, 8'hA3, 8'h8C, 8'hBF, 8'hBF, 8'h92, 8'h87,
        8'hC1, 8'hBF, 8'hBF, 8'hBF, 8'h91, 8'hA2
    };

    function automatic logic [SEG_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
        logic [SEG_W-1:0] code;
        if (c >= 8'h30 && c <= 8'h39) begin
            code = NUM_CODES[4'(c - 8'h30)];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            code = ALPHA_CODES[5'(c - 8'h41)];
        end else if (c == 8'h20) begin
            code = SEG_DARK;
        end else begin
            code = SEG_DASH;
        end
        return code;
    endfunction

    function automatic logic [SEG_W-1:0] decode_num(input logic [3:0] v);
        return (v < 4'd10) ? NUM_CODES[v] : SEG_DASH;
    endfunction

endpackage

/* rtl/core/ssmd_if.sv */
interface ssmd_in_if;
    logic                         valid;
    logic                         ready;
    logic [ssmd_pkg::REQ_W-1:0]   req_type;
    logic [ssmd_pkg::IDX_W-1:0]   digit_index;
    logic [ssmd_pkg::CHAR_W-1:0]  char_code;
    logic [ssmd_pkg::SCORE_W-1:0] score_value;

    modport source (output valid, req_type, digit_index, char_code, score_value,
                    input ready);
    modport sink   (input valid, req_type, digit_index, char_code, score_value,
                    output ready);
endinterface

interface ssmd_out_if;
    logic                       valid;
    logic                       ready;
    logic [ssmd_pkg::EN_W-1:0]  digit_enable;
    logic [ssmd_pkg::SEG_W-1:0] segments;

    modport source (output valid, digit_enable, segments, input ready);
    modport sink   (input valid, digit_enable, segments, output ready);
endinterface

interface ssmd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ssmd_pkg::CFG_IDX_W-1:0]  index;
    logic [ssmd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/seven_segment_mux_display.sv */
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    req_type, digit_index, char_code, score_value
// o_out     out  valid/ready    digit_enable, segments
// i_cfg     in   valid/ready    index, data (always ready)
//
// One item per clock while i_in.ready is high: the scan step, including the skip over used-up and
// empty phases, is combinational and lands in the output register.
// A two-entry output stage (register plus skid) keeps i_in.ready high while
// one result waits; ready drops only when both entries are full.
// Synchronous active-low reset: blank digits, digit 0 lit phase, counter 0,
// brightness 100/100, gap 500.
`include "assert_macros.svh"

module seven_segment_mux_display #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssmd_in_if.sink     i_in,
    ssmd_out_if.source  o_out,
    ssmd_cfg_if.sink    i_cfg
);

    localparam int PHASES = 2 * DIGIT_COUNT;
    localparam int PH_W   = $clog2(PHASES);
    localparam int POS_W  = PH_W - 1;
    localparam int SUM_W  = PH_W + 1;

    localparam int EN_W   = ssmd_pkg::EN_W;
    localparam int SEG_W  = ssmd_pkg::SEG_W;
    localparam int TICK_W = ssmd_pkg::TICK_W;

    localparam int SCORE_MUL_W = 8;

    // configuration
    logic [ssmd_pkg::BRIGHT_W-1:0] r_left_bright;
    logic [ssmd_pkg::BRIGHT_W-1:0] r_right_bright;
    logic [TICK_W-1:0]             r_gap_ticks;

    // scan state: phase = {digit position, gap flag}
    logic [PH_W-1:0]   r_phase,  n_phase;
    logic [TICK_W-1:0] r_ticks,  n_ticks;
    logic [SEG_W-1:0]  r_codes [DIGIT_COUNT];
    logic [SEG_W-1:0]  n_codes [DIGIT_COUNT];

    // output stage
    logic             r_out_valid;
    logic [EN_W-1:0]  r_out_en;
    logic [SEG_W-1:0] r_out_seg;
    logic             r_skid_valid;
    logic [EN_W-1:0]  r_skid_en;
    logic [SEG_W-1:0] r_skid_seg;

    logic             in_accept;
    logic             out_pop;
    logic [EN_W-1:0]  res_en;
    logic [SEG_W-1:0] res_seg;

    logic [TICK_W-1:0]          cur_len;
    logic                       exhausted;
    logic                       hit_found;
    logic [PH_W-1:0]            hit_phase;
    logic [2*SCORE_MUL_W-1:0]   score_prod;
    logic [3:0]                 tens;
    logic [ssmd_pkg::SCORE_W-1:0] units_full;
    logic [SEG_W-1:0]           tens_code;
    logic [SEG_W-1:0]           units_code;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_pop     = r_out_valid && o_out.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.digit_enable = r_out_en;
    assign o_out.segments     = r_out_seg;

    // length of the phase in force
    always_comb begin
        if (r_phase[0]) begin
            cur_len = r_gap_ticks;
        end else if (int'(r_phase[PH_W-1:1]) < 2) begin
            cur_len = TICK_W'(r_left_bright);
        end else begin
            cur_len = TICK_W'(r_right_bright);
        end
    end

    assign exhausted = (r_ticks >= cur_len);

    // first phase after the current one with a nonzero length
    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [PH_W-1:0]  q;
        logic             zero_len;
        hit_found = 1'b0;
        hit_phase = r_phase;
        for (int k = PHASES; k >= 1; k--) begin
            sum = SUM_W'(r_phase) + SUM_W'(k);
            if (sum >= SUM_W'(PHASES)) begin
                sum = sum - SUM_W'(PHASES);
            end
            q = PH_W'(sum);
            if (q[0]) begin
                zero_len = (r_gap_ticks == '0);
            end else if (int'(q[PH_W-1:1]) < 2) begin
                zero_len = (r_left_bright == '0);
            end else begin
                zero_len = (r_right_bright == '0);
            end
            if (!zero_len) begin
                hit_found = 1'b1;
                hit_phase = q;
            end
        end
    end

    // split the score: multiply by reciprocal of ten, exact for 7-bit values
    assign score_prod = (2*SCORE_MUL_W)'(i_in.score_value) * (2*SCORE_MUL_W)'(205);
    assign tens       = 4'(score_prod >> 11);
    assign units_full = i_in.score_value
                        - ssmd_pkg::SCORE_W'(tens) * ssmd_pkg::SCORE_W'(10);
    assign tens_code  = ssmd_pkg::decode_num(tens);
    assign units_code = ssmd_pkg::decode_num(4'(units_full));

    always_comb begin
        logic dark;
        logic is_right;
        logic [POS_W-1:0] pos;
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_codes  = r_codes;
        dark     = 1'b0;
        is_right = 1'b0;
        if (in_accept) begin
            unique case (ssmd_pkg::t_req'(i_in.req_type)) inside
                ssmd_pkg::REQ_TICK: begin
                    if (!exhausted) begin
                        n_ticks = r_ticks + 1'b1;
                    end else if (hit_found) begin
                        n_phase = hit_phase;
                        n_ticks = TICK_W'(1);
                    end else begin
                        // every phase empty: stay dark
                        n_ticks = '0;
                        dark    = 1'b1;
                    end
                end
                ssmd_pkg::REQ_CHAR: begin
                    if (int'(i_in.digit_index) < DIGIT_COUNT) begin
                        n_codes[POS_W'(i_in.digit_index)] =
                            ssmd_pkg::decode_char(i_in.char_code);
                    end
                end
                ssmd_pkg::REQ_LEFT, ssmd_pkg::REQ_RIGHT: begin
                    is_right = (ssmd_pkg::t_req'(i_in.req_type) == ssmd_pkg::REQ_RIGHT);
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (i == (is_right ? 2 : 0)) begin
                            n_codes[i] = tens_code;
                        end
                        if (i == (is_right ? 3 : 1)) begin
                            n_codes[i] = units_code;
                        end
                    end
                end
            endcase
        end

        pos     = n_phase[PH_W-1:1];
        res_en  = '0;
        res_seg = ssmd_pkg::SEG_DARK;
        if (!dark && !n_phase[0]) begin
            for (int i = 0; i < EN_W; i++) begin
                res_en[i] = (int'(pos) == i);
            end
            res_seg = n_codes[pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bright  <= ssmd_pkg::LEFT_BRIGHT_RST;
            r_right_bright <= ssmd_pkg::RIGHT_BRIGHT_RST;
            r_gap_ticks    <= ssmd_pkg::GAP_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ssmd_pkg::CFG_LEFT_BRIGHT:  r_left_bright  <= ssmd_pkg::BRIGHT_W'(i_cfg.data);
                ssmd_pkg::CFG_RIGHT_BRIGHT: r_right_bright <= ssmd_pkg::BRIGHT_W'(i_cfg.data);
                ssmd_pkg::CFG_GAP_TICKS:    r_gap_ticks    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_ticks <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_codes[i] <= ssmd_pkg::SEG_DARK;
            end
        end else begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_codes <= n_codes;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop && r_skid_valid) begin
            r_out_en  <= r_skid_en;
            r_out_seg <= r_skid_seg;
        end else if (in_accept && (out_pop || !r_out_valid)) begin
            r_out_en  <= res_en;
            r_out_seg <= res_seg;
        end
        if (in_accept && r_out_valid && !out_pop) begin
            r_skid_en  <= res_en;
            r_skid_seg <= res_seg;
        end
    end

    `ASSERT_CLK(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid,
        "skid entry holds an item while the output register is empty")
    `ASSERT_CLK(a_enable_onehot0, i_clk, i_rst_n, r_out_valid |-> $onehot0(r_out_en),
        "more than one digit enabled")
    `ASSERT_CLK(a_dark_segments, i_clk, i_rst_n,
        (r_out_valid && r_out_en == '0) |-> (r_out_seg == ssmd_pkg::SEG_DARK),
        "segments lit while no digit is enabled")
    `ASSERT_CLK(a_skid_drains, i_clk, i_rst_n,
        (r_out_valid && o_out.ready && r_skid_valid) |=> (r_out_valid && !r_skid_valid),
        "skid item lost on drain")
    `ASSERT_ALWAYS(a_phase_range, i_clk, int'(r_phase) < PHASES || !i_rst_n,
        "scan phase out of range")

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int SCAN_DIGITS  = 4;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 48;
    localparam int TARGET_ITEMS = 700;
    localparam int DIR_N        = 24;
    localparam logic [ssmd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        ssmd_pkg::t_req                req;
        logic [ssmd_pkg::IDX_W-1:0]    idx;
        logic [ssmd_pkg::CHAR_W-1:0]   chr;
        logic [ssmd_pkg::SCORE_W-1:0]  score;
    } t_cmd;

    typedef struct packed {
        logic [ssmd_pkg::EN_W-1:0]  en;
        logic [ssmd_pkg::SEG_W-1:0] seg;
    } t_disp;

    typedef struct packed {
        t_cmd  cmd;
        logic  fixed;
        t_disp want;
    } t_row;

    localparam logic [ssmd_pkg::SEG_W-1:0] DIGIT_FONT [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // letters K M Q R V W X have no shape and show a dash
    localparam logic [ssmd_pkg::SEG_W-1:0] LETTER_FONT [26] = '{
        8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h90, 8'h89, 8'hCF, 8'h61,
        8'hBF, 8'hC7, 8'hBF, 8'hAB, 8'hA3, 8'h8C, 8'hBF, 8'hBF, 8'h92, 8'h87,
        8'hC1, 8'hBF, 8'hBF, 8'hBF, 8'h91, 8'hA2
    };

    // fixed rows: expected display readable straight from the reset state
    t_row dir_rows [DIR_N] = '{
        '{'{ssmd_pkg::REQ_TICK,  2'd3, 8'hFF, 7'h7F}, 1'b1, '{4'h1, 8'hFF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h30, 7'h00}, 1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd1, 8'h39, 7'h00}, 1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd2, 8'h41, 7'h00}, 1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd3, 8'h5A, 7'h7F}, 1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_TICK,  2'd0, 8'h00, 7'h00}, 1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h20, 7'h00}, 1'b1, '{4'h1, 8'hFF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h61, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'hFF, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h00, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h4B, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h4A, 7'h00}, 1'b1, '{4'h1, 8'h61}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h2F, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h3A, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h40, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd0, 8'h5B, 7'h00}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_LEFT,  2'd0, 8'h00, 7'd0},  1'b1, '{4'h1, 8'hC0}},
        '{'{ssmd_pkg::REQ_LEFT,  2'd3, 8'hFF, 7'd127}, 1'b1, '{4'h1, 8'hBF}},
        '{'{ssmd_pkg::REQ_LEFT,  2'd0, 8'h00, 7'd99}, 1'b1, '{4'h1, 8'h90}},
        '{'{ssmd_pkg::REQ_RIGHT, 2'd0, 8'h00, 7'd100}, 1'b1, '{4'h1, 8'h90}},
        '{'{ssmd_pkg::REQ_RIGHT, 2'd0, 8'h00, 7'd9},  1'b1, '{4'h1, 8'h90}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd1, 8'h4D, 7'h00}, 1'b0, '{4'h0, 8'h00}},
        '{'{ssmd_pkg::REQ_CHAR,  2'd3, 8'h59, 7'h00}, 1'b0, '{4'h0, 8'h00}},
        '{'{ssmd_pkg::REQ_TICK,  2'd1, 8'h5A, 7'h2A}, 1'b0, '{4'h0, 8'h00}}
    };

    logic clk = 1'b0;
    logic rst_n;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ssmd_in_if  in_if ();
    ssmd_out_if out_if ();
    ssmd_cfg_if cfg_if ();

    seven_segment_mux_display #(
        .DIGIT_COUNT(SCAN_DIGITS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // display model state
    logic [ssmd_pkg::SEG_W-1:0]    shown_code [SCAN_DIGITS];
    logic [1:0]                    scan_pos;
    logic                          dark_phase;
    logic [ssmd_pkg::TICK_W-1:0]   spent;
    logic [ssmd_pkg::BRIGHT_W-1:0] lit_left;
    logic [ssmd_pkg::BRIGHT_W-1:0] lit_right;
    logic [ssmd_pkg::TICK_W-1:0]   gap_len;

    t_disp pending_displays [$];

    int  items_sent  = 0;
    int  results_seen = 0;
    int  settings    = 0;
    int  mismatches  = 0;
    bit  in_idle_on  = 1'b1;
    bit  out_idle_on = 1'b1;
    bit  hold_req    = 1'b0;

    function automatic logic [ssmd_pkg::SEG_W-1:0] glyph(
        input logic [ssmd_pkg::CHAR_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return DIGIT_FONT[c - 8'h30];
        if (c >= 8'h41 && c <= 8'h5A) return LETTER_FONT[c - 8'h41];
        if (c == 8'h20) return ssmd_pkg::SEG_DARK;
        return ssmd_pkg::SEG_DASH;
    endfunction

    function automatic logic [ssmd_pkg::SEG_W-1:0] score_digit(input int v);
        return (v < 10) ? DIGIT_FONT[v] : ssmd_pkg::SEG_DASH;
    endfunction

    function automatic logic [ssmd_pkg::TICK_W-1:0] phase_len();
        if (dark_phase) return gap_len;
        return (scan_pos < 2) ? ssmd_pkg::TICK_W'(lit_left) : ssmd_pkg::TICK_W'(lit_right);
    endfunction

    function automatic t_disp current_view();
        t_disp v;
        if (dark_phase) begin
            v.en  = '0;
            v.seg = ssmd_pkg::SEG_DARK;
        end else begin
            v.en  = ssmd_pkg::EN_W'(1) << scan_pos;
            v.seg = shown_code[scan_pos];
        end
        return v;
    endfunction

    function automatic t_disp next_display(input t_cmd c);
        t_disp v;
        int    skips;
        int    base;
        skips = 0;
        case (c.req)
            ssmd_pkg::REQ_TICK: begin
                // skip used-up and empty phases, bounded when all are empty
                while (spent >= phase_len() && skips < 2 * SCAN_DIGITS) begin
                    if (dark_phase) scan_pos = scan_pos + 1'b1;
                    dark_phase = !dark_phase;
                    spent = '0;
                    skips++;
                end
                if (spent >= phase_len()) begin
                    v.en  = '0;
                    v.seg = ssmd_pkg::SEG_DARK;
                end else begin
                    v = current_view();
                    spent = spent + 1'b1;
                end
            end
            ssmd_pkg::REQ_CHAR: begin
                shown_code[c.idx] = glyph(c.chr);
                v = current_view();
            end
            default: begin
                base = (c.req == ssmd_pkg::REQ_LEFT) ? 0 : 2;
                shown_code[base]     = score_digit(int'(c.score) / 10);
                shown_code[base + 1] = score_digit(int'(c.score) % 10);
                v = current_view();
            end
        endcase
        return v;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        c.req   = ssmd_pkg::REQ_TICK;
        c.idx   = ssmd_pkg::IDX_W'($urandom_range(0, 3));
        c.chr   = ssmd_pkg::CHAR_W'($urandom_range(0, 255));
        c.score = ssmd_pkg::SCORE_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            c.req = ssmd_pkg::REQ_TICK;
        end else if (pick < 82) begin
            c.req = ssmd_pkg::REQ_CHAR;
            case ($urandom_range(0, 5)) inside
                0, 1: c.chr = ssmd_pkg::CHAR_W'($urandom_range(8'h30, 8'h39));
                2, 3: c.chr = ssmd_pkg::CHAR_W'($urandom_range(8'h41, 8'h5A));
                4: c.chr = 8'h20;
                default: ;
            endcase
        end else if (pick < 91) begin
            c.req = ssmd_pkg::REQ_LEFT;
        end else begin
            c.req = ssmd_pkg::REQ_RIGHT;
        end
        return c;
    endfunction

    function automatic logic [ssmd_pkg::CFG_DATA_W-1:0] pick_len(input int top);
        if ($urandom_range(0, 9) == 0) return ssmd_pkg::CFG_DATA_W'(top);
        return ssmd_pkg::CFG_DATA_W'($urandom_range(0, 4));
    endfunction

    task automatic flag_mismatch(input string what, input t_disp want, input t_disp got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected en=%h seg=%h, got en=%h seg=%h",
                     $realtime, what, want.en, want.seg, got.en, got.seg);
    endtask

    task automatic offer(input t_cmd c, input logic fixed, input t_disp typed_want);
        int    gap;
        t_disp want;
        gap = in_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.req_type    <= c.req;
        in_if.digit_index <= c.idx;
        in_if.char_code   <= c.chr;
        in_if.score_value <= c.score;
        do @(posedge clk); while (!in_if.ready);
        want = next_display(c);
        pending_displays.push_back(fixed ? typed_want : want);
        items_sent++;
    endtask

    task automatic wait_empty();
        in_if.valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ssmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssmd_pkg::CFG_DATA_W-1:0] data, input bit last);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            ssmd_pkg::CFG_LEFT_BRIGHT:  lit_left  = data[ssmd_pkg::BRIGHT_W-1:0];
            ssmd_pkg::CFG_RIGHT_BRIGHT: lit_right = data[ssmd_pkg::BRIGHT_W-1:0];
            ssmd_pkg::CFG_GAP_TICKS:    gap_len   = data[ssmd_pkg::TICK_W-1:0];
            default: ;
        endcase
        // keep valid up across back-to-back writes
        if (last) cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [ssmd_pkg::CFG_DATA_W-1:0] lb,
                             input logic [ssmd_pkg::CFG_DATA_W-1:0] rb,
                             input logic [ssmd_pkg::CFG_DATA_W-1:0] gp, input int n);
        wait_empty();
        write_reg(ssmd_pkg::CFG_LEFT_BRIGHT, lb, 1'b0);
        write_reg(ssmd_pkg::CFG_RIGHT_BRIGHT, rb, 1'b0);
        write_reg(ssmd_pkg::CFG_GAP_TICKS, gp, 1'b1);
        settings++;
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
        repeat (n) offer(random_cmd(), 1'b0, '0);
    endtask

    initial begin : stimulus
        in_if.valid       = 1'b0;
        in_if.req_type    = ssmd_pkg::REQ_TICK;
        in_if.digit_index = '0;
        in_if.char_code   = '0;
        in_if.score_value = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = ssmd_pkg::CFG_LEFT_BRIGHT;
        cfg_if.data       = '0;
        rst_n             = 1'b0;
        for (int i = 0; i < SCAN_DIGITS; i++) shown_code[i] = ssmd_pkg::SEG_DARK;
        scan_pos   = '0;
        dark_phase = 1'b0;
        spent      = '0;
        lit_left   = ssmd_pkg::LEFT_BRIGHT_RST;
        lit_right  = ssmd_pkg::RIGHT_BRIGHT_RST;
        gap_len    = ssmd_pkg::GAP_TICKS_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            offer(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want);
        repeat (40) offer(random_cmd(), 1'b0, '0);

        run_phase(10'd0, 10'd0, 10'd0, 30);
        run_phase(10'd255, 10'd0, 10'd1023, 40);
        run_phase(10'd0, 10'd255, 10'd0, 40);

        // brightness takes only its low byte; the spare index is dropped
        wait_empty();
        write_reg(ssmd_pkg::CFG_LEFT_BRIGHT, 10'h301, 1'b0);
        write_reg(CFG_SPARE, 10'h2AA, 1'b0);
        write_reg(ssmd_pkg::CFG_RIGHT_BRIGHT, 10'h3FF, 1'b0);
        write_reg(ssmd_pkg::CFG_GAP_TICKS, 10'd2, 1'b1);
        settings++;
        repeat (40) offer(random_cmd(), 1'b0, '0);

        // back up the output while items keep coming, then pause for the drain
        run_phase(10'd1, 10'd2, 10'd0, 0);
        in_idle_on = 1'b0;
        hold_req   = 1'b1;
        repeat (60) offer(random_cmd(), 1'b0, '0);
        wait_empty();
        in_idle_on = 1'b1;
        repeat (60) offer(random_cmd(), 1'b0, '0);

        while (items_sent < TARGET_ITEMS)
            run_phase(pick_len(255), pick_len(255), pick_len(1023), 60);

        wait_empty();
        repeat (8) @(posedge clk);
        $display("covered %0d items (%0d table rows), %0d results, %0d register settings",
                 items_sent, DIR_N, results_seen, settings);
        $display("all request kinds, empty and full-length phases, %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_check
        t_disp want;
        t_disp got;
        int    stall;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = out_idle_on ? $urandom_range(0, 15) : 0;
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge clk); while (out_if.valid !== 1'b1);
            got.en  = out_if.digit_enable;
            got.seg = out_if.segments;
            results_seen++;
            if (pending_displays.size() == 0) begin
                flag_mismatch("result with none expected", '0, got);
            end else begin
                want = pending_displays.pop_front();
                if (got.en !== want.en) flag_mismatch("digit_enable", want, got);
                if (got.seg !== want.seg) flag_mismatch("segments", want, got);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, %0d results still expected",
                 IDLE_LIMIT, pending_displays.size());
        $display("FAIL");
        $finish;
    end

endmodule
